/* rtl/fcev_pkg.sv */
// Package for the formation cost evaluator: codes, widths and reset values.
// No dependencies; used by formation_cost_evaluator.sv and the testbench.
`default_nettype none

package fcev_pkg;

    localparam int FCEV_MAX_NEIGHBORS = 64;

    localparam int COORD_W   = 16;
    localparam int POINT_W   = 3 * COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = POINT_W;
    localparam int COST_W    = 48;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;        // exact coordinate difference
    localparam int SQ_W   = 2 * DIFF_W;         // one square
    localparam int D2_W   = SQ_W;               // sum of three squares still fits
    localparam int WGT_W  = 16;
    localparam int PROD_W = WGT_W + D2_W;
    localparam int RAD_W  = 15;
    localparam int ROOT_W = D2_W / 2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_APPEND   = 2'd1,
        ACT_EVALUATE = 2'd2,
        ACT_UNUSED   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMATION_WEIGHT = 3'd0,
        REG_COLLISION_WEIGHT = 3'd1,
        REG_SMOOTH_WEIGHT    = 3'd2,
        REG_SAFE_RADIUS      = 3'd3,
        REG_COHESION_RADIUS  = 3'd4,
        REG_DESIRED_POINT    = 3'd5,
        REG_PREVIOUS_TARGET  = 3'd6,
        REG_NONE             = 3'd7
    } cfg_index_t;

    localparam logic [WGT_W-1:0]   RST_FORMATION_WEIGHT = 16'd256;
    localparam logic [WGT_W-1:0]   RST_COLLISION_WEIGHT = 16'd256;
    localparam logic [WGT_W-1:0]   RST_SMOOTH_WEIGHT    = 16'd0;
    localparam logic [RAD_W-1:0]   RST_SAFE_RADIUS      = 15'd512;
    localparam logic [RAD_W-1:0]   RST_COHESION_RADIUS  = 15'd2560;

    // Which point the shared datapath is scoring
    typedef enum logic [1:0] {
        SRC_FORM   = 2'd0,
        SRC_NEIGH  = 2'd1,
        SRC_SMOOTH = 2'd2,
        SRC_NONE   = 2'd3
    } src_t;

endpackage

`default_nettype wire

/* rtl/fcev_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcev_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/formation_cost_evaluator.sv */
// Formation cost evaluator top level: neighbor table, config registers, cost datapath.
// Depends on fcev_pkg and fcev_ram.
//
//  Channel  Signals                                    Transfer
//  -------  -----------------------------------------  --------------------------------
//  cmd      start, action, coord_x/y/z, busy           edge with start=1 and busy=0
//  result   done, cost, cost_saturated,                edge that ends the done cycle
//           neighbors_dropped
//  config   cfg_we, cfg_index, cfg_data                edge with cfg_we=1
//
// Clear, append and unused codes are handled in the idle state; busy stays low.
// Evaluate: square both radii, then per point (desired, each neighbor, previous
// target) read and load it and square the three axis differences. A neighbor in penalty
// adds the root, penalty, penalty square, weight and accumulate steps, one in the
// free band a single accumulate step; the desired and previous points add weight and
// accumulate. All on one shared squarer, one weight multiplier and the iterative
// square root.
// done pulses for one cycle, starting on the edge at which busy falls.
// Asynchronous active-low reset clears control state, count and drop flag.
// Table read data is used only while evaluating; the table is written only while idle.
`default_nettype none

module formation_cost_evaluator
    import fcev_pkg::*;
#(
    parameter int MAX_NEIGHBORS = FCEV_MAX_NEIGHBORS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            action,
    input  wire logic [COORD_W-1:0]    coord_x,
    input  wire logic [COORD_W-1:0]    coord_y,
    input  wire logic [COORD_W-1:0]    coord_z,
    output logic                       done,
    output logic [COST_W-1:0]          cost,
    output logic                       cost_saturated,
    output logic                       neighbors_dropped,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_NEIGHBORS);

    typedef enum logic [3:0] {
        S_IDLE, S_RAD0, S_RAD1, S_RD, S_LOAD, S_SQ,
        S_ROOT, S_PEN, S_PSQ, S_WMUL, S_ACC
    } state_t;

    // Configuration registers
    logic [WGT_W-1:0]   form_w_reg, coll_w_reg, smooth_w_reg;
    logic [RAD_W-1:0]   safe_r_reg, coh_r_reg;
    logic [POINT_W-1:0] desired_reg, previous_reg;

    // Control and datapath registers
    state_t             state_reg;
    src_t               src_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic               dropped_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [POINT_W-1:0] pt_reg;
    logic [1:0]         axis_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [D2_W-1:0]    safe2_reg, coh2_reg;
    logic               near_reg;
    logic [D2_W-1:0]    rem_reg;
    logic [D2_W:0]      res_reg;
    logic [D2_W-1:0]    bit_reg;
    logic [DIFF_W-1:0]  pen_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COST_W-1:0]  acc_reg;
    logic               done_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               sat_reg;
    logic               drop_out_reg;

    // Table RAM
    logic               ram_we;
    logic [POINT_W-1:0] ram_rdata;
    logic               accept;

    assign accept = start && (state_reg == S_IDLE);
    assign ram_we = accept && (action == ACT_APPEND) && (count_reg < MAX_COUNT);

    fcev_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_NEIGHBORS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({coord_z, coord_y, coord_x}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Per-axis difference magnitude
    logic [COORD_W-1:0] c_sel, p_sel;
    logic [DIFF_W-1:0]  diff, mag;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                c_sel = cx_reg;
                p_sel = pt_reg[COORD_W-1:0];
            end
            2'd1:
            begin
                c_sel = cy_reg;
                p_sel = pt_reg[2*COORD_W-1:COORD_W];
            end
            default:
            begin
                c_sel = cz_reg;
                p_sel = pt_reg[3*COORD_W-1:2*COORD_W];
            end
        endcase
        diff = {c_sel[COORD_W-1], c_sel} - {p_sel[COORD_W-1], p_sel};
        mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    end

    // Shared squarer
    logic [DIFF_W-1:0] sq_in;
    logic [SQ_W-1:0]   sq_out;

    always_comb
    begin
        unique case (state_reg)
            S_RAD0:  sq_in = DIFF_W'(safe_r_reg);
            S_RAD1:  sq_in = DIFF_W'(coh_r_reg);
            S_PSQ:   sq_in = pen_reg;
            default: sq_in = mag;
        endcase
        sq_out = sq_in * sq_in;
    end

    // Root step
    logic [D2_W:0]   trial;
    logic            take;

    assign trial = res_reg + {1'b0, bit_reg};
    assign take  = {1'b0, rem_reg} >= trial;

    // Weight multiplier
    logic [WGT_W-1:0] w_sel;

    always_comb
    begin
        unique case (src_reg)
            SRC_FORM:   w_sel = form_w_reg;
            SRC_NEIGH:  w_sel = coll_w_reg;
            SRC_SMOOTH: w_sel = smooth_w_reg;
            default:    w_sel = '0;
        endcase
    end

    // Saturating accumulate; far-side hinge has half weight
    logic [PROD_W-1:0] term;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] sum_sat;

    always_comb
    begin
        if (src_reg == SRC_NEIGH && !near_reg)
        begin
            term = prod_reg >> 9;
        end
        else
        begin
            term = prod_reg >> 8;
        end
        sum     = {1'b0, acc_reg} + (COST_W + 1)'(term);
        sum_sat = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    end

    // Next point to score
    src_t          src_adv;
    logic [CW-1:0] idx_adv;

    always_comb
    begin
        idx_adv = '0;
        priority case (src_reg)
            SRC_FORM:
            begin
                src_adv = (count_reg != '0) ? SRC_NEIGH : SRC_SMOOTH;
            end
            SRC_NEIGH:
            begin
                idx_adv = idx_reg + CW'(1);
                src_adv = (idx_adv < count_reg) ? SRC_NEIGH : SRC_SMOOTH;
            end
            default:
            begin
                src_adv = SRC_NONE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_w_reg   <= RST_FORMATION_WEIGHT;
            coll_w_reg   <= RST_COLLISION_WEIGHT;
            smooth_w_reg <= RST_SMOOTH_WEIGHT;
            safe_r_reg   <= RST_SAFE_RADIUS;
            coh_r_reg    <= RST_COHESION_RADIUS;
            desired_reg  <= '0;
            previous_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FORMATION_WEIGHT: form_w_reg   <= cfg_data[WGT_W-1:0];
                REG_COLLISION_WEIGHT: coll_w_reg   <= cfg_data[WGT_W-1:0];
                REG_SMOOTH_WEIGHT:    smooth_w_reg <= cfg_data[WGT_W-1:0];
                REG_SAFE_RADIUS:      safe_r_reg   <= cfg_data[RAD_W-1:0];
                REG_COHESION_RADIUS:  coh_r_reg    <= cfg_data[RAD_W-1:0];
                REG_DESIRED_POINT:    desired_reg  <= cfg_data[POINT_W-1:0];
                REG_PREVIOUS_TARGET:  previous_reg <= cfg_data[POINT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer, datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            src_reg      <= SRC_NONE;
            count_reg    <= '0;
            idx_reg      <= '0;
            dropped_reg  <= 1'b0;
            done_reg     <= 1'b0;
            axis_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (action_t'(action))
                            ACT_CLEAR:
                            begin
                                count_reg   <= '0;
                                dropped_reg <= 1'b0;
                            end
                            ACT_APPEND:
                            begin
                                if (count_reg < MAX_COUNT)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                else
                                begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            ACT_EVALUATE:
                            begin
                                cx_reg    <= coord_x;
                                cy_reg    <= coord_y;
                                cz_reg    <= coord_z;
                                acc_reg   <= '0;
                                src_reg   <= SRC_FORM;
                                idx_reg   <= '0;
                                state_reg <= S_RAD0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RAD0:
                begin
                    safe2_reg <= sq_out;
                    state_reg <= S_RAD1;
                end
                S_RAD1:
                begin
                    coh2_reg  <= sq_out;
                    state_reg <= S_RD;
                end
                // RAM address is stable for this cycle; data valid next
                S_RD:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    unique case (src_reg)
                        SRC_FORM:  pt_reg <= desired_reg;
                        SRC_NEIGH: pt_reg <= ram_rdata;
                        default:   pt_reg <= previous_reg;
                    endcase
                    axis_reg  <= '0;
                    d2_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    d2_reg   <= d2_reg + sq_out;
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        if (src_reg != SRC_NEIGH)
                        begin
                            state_reg <= S_WMUL;
                        end
                        else if ((d2_reg + sq_out) < safe2_reg)
                        begin
                            near_reg  <= 1'b1;
                            state_reg <= S_ROOT;
                        end
                        else if ((d2_reg + sq_out) > coh2_reg)
                        begin
                            near_reg  <= 1'b0;
                            state_reg <= S_ROOT;
                        end
                        else
                        begin
                            near_reg  <= 1'b1;
                            prod_reg  <= '0;
                            state_reg <= S_ACC;
                        end
                        rem_reg <= d2_reg + sq_out;
                        res_reg <= '0;
                        bit_reg <= D2_W'(1) << (D2_W - 2);
                    end
                end
                // One result bit per cycle, floor square root
                S_ROOT:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - trial[D2_W-1:0];
                        res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= S_PEN;
                    end
                end
                S_PEN:
                begin
                    if (near_reg)
                    begin
                        pen_reg <= DIFF_W'(safe_r_reg) - res_reg[DIFF_W-1:0];
                    end
                    else
                    begin
                        pen_reg <= res_reg[DIFF_W-1:0] - DIFF_W'(coh_r_reg);
                    end
                    state_reg <= S_PSQ;
                end
                S_PSQ:
                begin
                    d2_reg    <= sq_out;
                    state_reg <= S_WMUL;
                end
                S_WMUL:
                begin
                    prod_reg  <= w_sel * d2_reg;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= sum_sat;
                    if (src_reg == SRC_SMOOTH)
                    begin
                        cost_reg     <= sum_sat;
                        sat_reg      <= (sum_sat == COST_MAX);
                        drop_out_reg <= dropped_reg;
                        done_reg     <= 1'b1;
                        src_reg      <= SRC_NONE;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        src_reg   <= src_adv;
                        idx_reg   <= idx_adv;
                        state_reg <= S_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign cost              = cost_reg;
    assign cost_saturated    = sat_reg;
    assign neighbors_dropped = drop_out_reg;

    // Checks
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without evaluation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("neighbor count beyond table depth");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cost_saturated == (cost == COST_MAX)))
        else $error("saturation flag disagrees with cost");

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_EVALUATE) |=> busy)
        else $error("evaluate transfer did not start work");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ram_we)
        else $error("table write during evaluation");

endmodule

`default_nettype wire

/* dv/formation_cost_evaluator_tb.sv */
// Self-checking testbench for formation_cost_evaluator: queue-fed command driver,
// result monitor and a cycle-free cost predictor. Depends on rtl/fcev_pkg.sv and the RTL.
`timescale 1ns / 100ps

module formation_cost_evaluator_tb;
    import fcev_pkg::*;

    typedef struct {
        action_t     act;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } cmd_t;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              sat;
        logic              dropped;
    } score_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            action = '0;
    logic [COORD_W-1:0]    coord_x = '0;
    logic [COORD_W-1:0]    coord_y = '0;
    logic [COORD_W-1:0]    coord_z = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   busy;
    wire                   done;
    wire  [COST_W-1:0]     cost;
    wire                   cost_saturated;
    wire                   neighbors_dropped;

    formation_cost_evaluator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .done(done),
        .cost(cost), .cost_saturated(cost_saturated),
        .neighbors_dropped(neighbors_dropped),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor copy of the registers and the neighbor table
    logic [15:0] m_form_w, m_coll_w, m_smooth_w;
    logic [14:0] m_safe_r, m_coh_r;
    logic [47:0] m_desired, m_prev;
    logic [47:0] m_table [FCEV_MAX_NEIGHBORS];
    int          m_count;
    bit          m_dropped;

    cmd_t   pending_cmds[$];
    score_t expected_scores[$];
    int     n_errors, n_scored, n_appends, n_drops_seen;
    bit     steady_mode;

    // ---------------- predictor ----------------
    function automatic longint unsigned sq_dist(logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z, logic [47:0] p);
        longint dx, dy, dz;
        dx = longint'($signed(x)) - longint'($signed(p[15:0]));
        dy = longint'($signed(y)) - longint'($signed(p[31:16]));
        dz = longint'($signed(z)) - longint'($signed(p[47:32]));
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'(COST_MAX) || s < a) ? 64'(COST_MAX) : s;
    endfunction

    function automatic score_t score_point(cmd_t c);
        longint unsigned acc, d2, safe2, coh2, pen, root;
        score_t r;
        acc = (64'(m_form_w) * sq_dist(c.x, c.y, c.z, m_desired)) >> 8;
        safe2 = 64'(m_safe_r) * 64'(m_safe_r);
        coh2 = 64'(m_coh_r) * 64'(m_coh_r);
        for (int i = 0; i < m_count; i++)
        begin
            d2 = sq_dist(c.x, c.y, c.z, m_table[i]);
            if (d2 < safe2)
            begin
                root = floor_sqrt(d2);
                pen = 64'(m_safe_r) - root;
                acc = add_sat(acc, (64'(m_coll_w) * (pen * pen)) >> 8);
            end
            else if (d2 > coh2)
            begin
                root = floor_sqrt(d2);
                pen = root - 64'(m_coh_r);
                acc = add_sat(acc, (64'(m_coll_w) * (pen * pen)) >> 9);
            end
        end
        acc = add_sat(acc, (64'(m_smooth_w) * sq_dist(c.x, c.y, c.z, m_prev)) >> 8);
        r.cost = acc[47:0];
        r.sat = (acc == 64'(COST_MAX));
        r.dropped = m_dropped;
        return r;
    endfunction

    // apply one accepted transfer to the predictor
    task automatic take_cmd(cmd_t c);
        case (c.act)
            ACT_CLEAR:
            begin
                m_count = 0;
                m_dropped = 0;
            end
            ACT_APPEND:
            begin
                n_appends++;
                if (m_count < FCEV_MAX_NEIGHBORS)
                begin
                    m_table[m_count] = {c.z, c.y, c.x};
                    m_count++;
                end
                else
                    m_dropped = 1;
            end
            ACT_EVALUATE:
                expected_scores.push_back(score_point(c));
            default: ;
        endcase
    endtask

    // ---------------- driver ----------------
    cmd_t cur_cmd;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                take_cmd(cur_cmd);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    action <= cur_cmd.act;
                    coord_x <= cur_cmd.x;
                    coord_y <= cur_cmd.y;
                    coord_z <= cur_cmd.z;
                    start <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else if (!steady_mode)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && done)
        begin
            if (expected_scores.size() == 0)
            begin
                $error("result with no evaluation outstanding, cost %0h", cost);
                n_errors++;
            end
            else
            begin
                want = expected_scores.pop_front();
                n_scored++;
                if (cost !== want.cost)
                begin
                    $error("cost: expected %0h actual %0h", want.cost, cost);
                    n_errors++;
                end
                if (cost_saturated !== want.sat)
                begin
                    $error("cost_saturated: expected %0b actual %0b", want.sat, cost_saturated);
                    n_errors++;
                end
                if (neighbors_dropped !== want.dropped)
                begin
                    $error("neighbors_dropped: expected %0b actual %0b",
                           want.dropped, neighbors_dropped);
                    n_errors++;
                end
                if (want.dropped)
                    n_drops_seen++;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(cfg_index_t idx, logic [47:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_FORMATION_WEIGHT: m_form_w = v[15:0];
            REG_COLLISION_WEIGHT: m_coll_w = v[15:0];
            REG_SMOOTH_WEIGHT:    m_smooth_w = v[15:0];
            REG_SAFE_RADIUS:      m_safe_r = v[14:0];
            REG_COHESION_RADIUS:  m_coh_r = v[14:0];
            REG_DESIRED_POINT:    m_desired = v;
            REG_PREVIOUS_TARGET:  m_prev = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] fw, logic [15:0] cw, logic [15:0] sw,
                             logic [14:0] sr, logic [14:0] cr,
                             logic [47:0] dp, logic [47:0] pt);
        write_reg(REG_FORMATION_WEIGHT, 48'(fw));
        write_reg(REG_COLLISION_WEIGHT, 48'(cw));
        write_reg(REG_SMOOTH_WEIGHT, 48'(sw));
        write_reg(REG_SAFE_RADIUS, 48'(sr));
        write_reg(REG_COHESION_RADIUS, 48'(cr));
        write_reg(REG_DESIRED_POINT, dp);
        write_reg(REG_PREVIOUS_TARGET, pt);
    endtask

    // sender pauses here until every evaluation has been scored
    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() > 0 || expected_scores.size() > 0 || start || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic push(action_t a, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        cmd_t c;
        c.act = a;
        c.x = x;
        c.y = y;
        c.z = z;
        pending_cmds.push_back(c);
    endtask

    // mostly within 4096 of the origin, sometimes full range or extremes
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
            1, 2:    return 16'($urandom);
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    task automatic push_rand(action_t a);
        push(a, pick_coord(), pick_coord(), pick_coord());
    endtask

    function automatic logic [47:0] rand_point();
        return {pick_coord(), pick_coord(), pick_coord()};
    endfunction

    initial
    begin
        int n_items, n_neigh;
        m_form_w = RST_FORMATION_WEIGHT;
        m_coll_w = RST_COLLISION_WEIGHT;
        m_smooth_w = RST_SMOOTH_WEIGHT;
        m_safe_r = RST_SAFE_RADIUS;
        m_coh_r = RST_COHESION_RADIUS;
        m_desired = '0;
        m_prev = '0;
        m_count = 0;
        m_dropped = 0;
        steady_mode = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset settings, extremes, each neighbor region, unused code
        push(ACT_EVALUATE, 16'h0000, 16'h0000, 16'h0000);
        push(ACT_EVALUATE, 16'h7fff, 16'h7fff, 16'h7fff);
        push(ACT_EVALUATE, 16'h8000, 16'h8000, 16'h8000);
        push(ACT_APPEND, 16'h0000, 16'h0000, 16'h0000);    // coincident neighbor
        push(ACT_APPEND, 16'h0100, 16'h0000, 16'h0000);    // inside safe radius
        push(ACT_APPEND, 16'h0000, 16'h0600, 16'h0000);    // in the free band
        push(ACT_APPEND, 16'h0000, 16'h0000, 16'h8000);    // beyond cohesion
        push(ACT_APPEND, 16'h7fff, 16'h8000, 16'h7fff);
        push(ACT_EVALUATE, 16'h0000, 16'h0000, 16'h0000);
        push(ACT_EVALUATE, 16'h0200, 16'h0000, 16'h0000);  // exactly at safe radius
        push(ACT_EVALUATE, 16'h8000, 16'h7fff, 16'h8000);
        push(ACT_UNUSED, 16'h1234, 16'h5678, 16'h9abc);
        push(ACT_EVALUATE, 16'h0000, 16'h0a00, 16'h0000);
        push(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        push(ACT_EVALUATE, 16'hffff, 16'h0001, 16'hffff);
        drain();

        // extreme settings: everything at zero, then maximum weights and radii with extreme points
        write_all('0, '0, '0, '0, '0, '0, '0);
        write_reg(REG_NONE, 48'hffff_ffff_ffff);
        push(ACT_APPEND, 16'h0100, 16'h0100, 16'h0100);
        push(ACT_EVALUATE, 16'h7fff, 16'h8000, 16'h0000);
        push(ACT_EVALUATE, 16'h0100, 16'h0100, 16'h0100);
        drain();
        write_all(16'hffff, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff,
                  48'h7fff_8000_7fff, 48'h8000_7fff_8000);
        push(ACT_EVALUATE, 16'h8000, 16'h7fff, 16'h8000);
        push(ACT_EVALUATE, 16'h0100, 16'h0100, 16'h0100);
        drain();

        // random phases; each starts from idle with fresh settings
        n_items = 0;
        for (int ph = 0; n_items < 900; ph++)
        begin
            if (ph % 4 == 3)
                write_all(16'hffff, 16'hffff, 16'hffff, '0, '0,
                          rand_point(), rand_point());
            else
                write_all(16'($urandom_range(0, 1024)), 16'($urandom),
                          ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom),
                          15'($urandom_range(0, 1536)), 15'($urandom_range(512, 4096)),
                          rand_point(), rand_point());
            steady_mode = (ph % 3 == 1);
            push(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            n_items++;
            // one phase in five fills the table, and most of those overfill it
            n_neigh = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 70)
                                                  : $urandom_range(0, 12);
            for (int i = 0; i < n_neigh; i++)
            begin
                push_rand(ACT_APPEND);
                if (n_neigh < 20 && $urandom_range(0, 2) == 0)
                begin
                    push_rand(ACT_EVALUATE);
                    n_items++;
                end
                n_items++;
            end
            for (int i = 0; i < $urandom_range(2, 8); i++)
            begin
                case ($urandom_range(0, 9))
                    0:       push_rand(ACT_UNUSED);
                    1:       push_rand(ACT_APPEND);
                    default: push_rand(ACT_EVALUATE);
                endcase
                n_items++;
            end
            drain();
        end

        $display("checked %0d evaluations (%0d with drop flag) over %0d appends",
                 n_scored, n_drops_seen, n_appends);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout: %0d evaluations still outstanding", expected_scores.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
